// ===== hw/rtl/length_prefix_stream_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Length-prefix deframer assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_STREAM_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_STREAM_DEFRAMER_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define LPSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lpsd assertion failed");

// Condition must never be true outside reset.
`define LPSD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lpsd forbidden condition seen");

`endif

// ===== hw/rtl/lpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer package
// Widths, constants and the result record shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  // Bytes in the length prefix on the wire (1..8); only the first four count.
  localparam int HEADER_BYTES = 4;
  localparam int LEN_BYTES    = 4;
  localparam int LEN_W        = 8 * LEN_BYTES;
  localparam int CNT_W        = 48;
  localparam int POS_W        = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(64 * 1024 * 1024);

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             last_of_packet;
    logic             empty_packet;
    logic             oversize_error;
    logic [CNT_W-1:0] packets_total;
    logic [CNT_W-1:0] payload_bytes_total;
  } lpsd_result_t;

endpackage

// ===== hw/rtl/lpsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer input stage
// Registers one incoming stream byte; stalls the sender while it waits.
// ----------------------------------------------------------------------------
module lpsd_in_stage
  import lpsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  input  logic       take_i,
  output logic       item_valid_o,
  output logic [7:0] item_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  // Refill when empty or when the held item moves on this cycle.
  assign load       = !valid_q || take_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q <= stream_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

// ===== hw/rtl/lpsd_core.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer core
// Header parse, payload countdown, running totals and the length limit.
// ----------------------------------------------------------------------------
`include "length_prefix_stream_deframer_defines.svh"

module lpsd_core
  import lpsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [LEN_W-1:0] cfg_max_packet_length_i,
  input  logic             advance_i,
  input  logic [7:0]       item_byte_i,
  output logic             res_valid_o,
  output lpsd_result_t     res_o
);

  logic [LEN_W-1:0] max_len_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             in_payload_q, in_payload_d;
  logic [CNT_W-1:0] pkt_q, pkt_d;
  logic [CNT_W-1:0] bytes_q, bytes_d;
  logic [LEN_W-1:0] lane;
  logic [LEN_W-1:0] acc;
  logic             res_valid;
  logic             res_last;
  logic             res_empty;
  logic             res_err;
  logic [7:0]       res_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_max_packet_length_i;
    end
  end

  // Place the byte in its lane of the length; positions past four drop out.
  always_comb begin
    lane = '0;
    for (int k = 0; k < LEN_BYTES; k++) begin
      if (k < HEADER_BYTES && int'(pos_q) == k) begin
        lane[8*k +: 8] = item_byte_i;
      end
    end
  end

  assign acc = len_q | lane;

  always_comb begin
    pos_d        = pos_q;
    len_d        = len_q;
    rem_d        = rem_q;
    in_payload_d = in_payload_q;
    pkt_d        = pkt_q;
    bytes_d      = bytes_q;
    res_valid    = 1'b0;
    res_last     = 1'b0;
    res_empty    = 1'b0;
    res_err      = 1'b0;
    res_byte     = '0;
    if (in_payload_q) begin
      res_valid = 1'b1;
      res_byte  = item_byte_i;
      rem_d     = rem_q - LEN_W'(1);
      if (rem_q == LEN_W'(1)) begin
        res_last     = 1'b1;
        pkt_d        = pkt_q + CNT_W'(1);
        bytes_d      = bytes_q + CNT_W'(len_q);
        len_d        = '0;
        in_payload_d = 1'b0;
      end
    end else if (pos_q == POS_LAST) begin
      pos_d = '0;
      if (acc > max_len_q) begin
        len_d     = '0;
        res_valid = 1'b1;
        res_err   = 1'b1;
      end else if (acc == '0) begin
        len_d     = '0;
        res_valid = 1'b1;
        res_last  = 1'b1;
        res_empty = 1'b1;
        pkt_d     = pkt_q + CNT_W'(1);
      end else begin
        len_d        = acc;
        rem_d        = acc;
        in_payload_d = 1'b1;
      end
    end else begin
      pos_d = pos_q + POS_W'(1);
      len_d = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      len_q        <= '0;
      rem_q        <= '0;
      in_payload_q <= 1'b0;
      pkt_q        <= '0;
      bytes_q      <= '0;
    end else if (advance_i) begin
      pos_q        <= pos_d;
      len_q        <= len_d;
      rem_q        <= rem_d;
      in_payload_q <= in_payload_d;
      pkt_q        <= pkt_d;
      bytes_q      <= bytes_d;
    end
  end

  assign res_valid_o               = advance_i && res_valid;
  assign res_o.payload_byte        = res_byte;
  assign res_o.last_of_packet      = res_last;
  assign res_o.empty_packet        = res_empty;
  assign res_o.oversize_error      = res_err;
  assign res_o.packets_total       = pkt_d;
  assign res_o.payload_bytes_total = bytes_d;

  `LPSD_ASSERT_NEVER(a_payload_mid_header, clk_i, rst_ni, in_payload_q && (pos_q != '0))
  `LPSD_ASSERT_NEVER(a_payload_no_remaining, clk_i, rst_ni, in_payload_q && (rem_q == '0))
  `LPSD_ASSERT(a_error_keeps_totals, clk_i, rst_ni,
    (res_valid_o && res_err) |=> ($stable(pkt_q) && $stable(bytes_q)))

endmodule

// ===== hw/rtl/lpsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer output stage
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lpsd_out_stage
  import lpsd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  input  lpsd_result_t res_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lpsd_result_t res_o
);

  logic         valid_q;
  lpsd_result_t res_q;

  // Free when empty or when the held item leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/length_prefix_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// Length-prefix stream deframer
// Splits a byte stream into packets framed by a little-endian length prefix.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per item on in_valid_i / in_stall_o.
// Output channel: one result per payload byte, per empty packet and per
//   oversize header on out_valid_o / out_stall_i; header bytes give none.
// Config channel: cfg_valid_i / cfg_ready_o writes the maximum length;
//   ready is always high, and a new limit applies to the next header check.
// Path: an accepted item lands in the input register; the core parses it
//   combinationally, and any result is loaded into the output register
//   once that register is free, which sets out_valid_o.
// Throughput: one item per cycle unless stalled, set by the single parse
//   step between the input and output registers; totals update in that step.
// Stall: while the output register is full and stalled, the input register
//   holds its item and in_stall_o rises; nothing is dropped.
// Reset: clears both registers, the parser (expecting a header), the
//   totals, and sets the maximum length to 64 MiB.
// ----------------------------------------------------------------------------
module length_prefix_stream_deframer
  import lpsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_max_packet_length_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       stream_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             last_of_packet_o,
  output logic             empty_packet_o,
  output logic             oversize_error_o,
  output logic [CNT_W-1:0] packets_total_o,
  output logic [CNT_W-1:0] payload_bytes_total_o
);

  logic         item_valid;
  logic [7:0]   item_byte;
  logic         out_ready;
  logic         advance;
  logic         res_valid;
  lpsd_result_t res;
  lpsd_result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign advance     = item_valid && out_ready;

  lpsd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .stream_byte_i(stream_byte_i),
    .take_i       (advance),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  lpsd_core u_core (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_max_packet_length_i(cfg_max_packet_length_i),
    .advance_i              (advance),
    .item_byte_i            (item_byte),
    .res_valid_o            (res_valid),
    .res_o                  (res)
  );

  lpsd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign payload_byte_o        = out_res.payload_byte;
  assign last_of_packet_o      = out_res.last_of_packet;
  assign empty_packet_o        = out_res.empty_packet;
  assign oversize_error_o      = out_res.oversize_error;
  assign packets_total_o       = out_res.packets_total;
  assign payload_bytes_total_o = out_res.payload_bytes_total;

endmodule
